// File: rtl/b64d_pkg.sv
// Package for the Base64 stream decoder: shared types, constants and the
// character-to-sextet map. No dependencies.
package b64d_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [1:0] GrpFirst  = 2'd0;
  localparam logic [1:0] GrpSecond = 2'd1;
  localparam logic [1:0] GrpThird  = 2'd2;
  localparam logic [1:0] GrpFourth = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       has_end;
  } cmd_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r.ok  = 1'b1;
      r.val = 6'd62;
    end else if (c == 8'h2F) begin
      r.ok  = 1'b1;
      r.val = 6'd63;
    end
    return r;
  endfunction

endpackage

// File: rtl/b64d_if.sv
// Stream channel interfaces for the Base64 decoder: character input and
// decoded result output. No dependencies.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       final_char;

  modport source (output valid, in_char, final_char, input ready);
  modport sink (input valid, in_char, final_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       stream_end;

  modport source (output valid, out_byte, byte_valid, run_last, stream_end, input ready);
  modport sink (input valid, out_byte, byte_valid, run_last, stream_end, output ready);
endinterface

// File: rtl/base64_stream_decoder_core.sv
// Base64 stream decoder, top level: one character per item in, decoded bytes out.
// A result passes the command queue and the output register before it is offered.
// Throughput: one character per cycle while the queue has room, set by the front
// end; a final character completing a byte yields the byte, then an end marker.
// Reset: asynchronous; clears group state, queue pointers, output valid and phase.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
module base64_stream_decoder_core #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64d_in_if.sink    in_i,
  b64d_out_if.source out_o
);
  import b64d_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  b64d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule

// File: rtl/b64d_front.sv
// Front end: accepts characters, tracks the group state and builds at most one
// command per character. Depends on b64d_pkg and b64d_in_if.
module b64d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  b64d_in_if.sink           in_i,
  input  logic              push_ready_i,
  output logic              push_valid_o,
  output b64d_pkg::cmd_t    push_cmd_o
);
  import b64d_pkg::*;

  logic [1:0] pos_q, pos_d;
  logic [5:0] s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic       stop_q, stop_d;
  logic       accept;
  logic       is_pad;
  sextet_t    sx;
  cmd_t       cmd;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid & push_ready_i;
  assign sx         = sextet_of(in_i.in_char);
  assign is_pad     = (in_i.in_char == PadChar);

  always_comb begin
    pos_d  = pos_q;
    s0_d   = s0_q;
    s1_d   = s1_q;
    s2_d   = s2_q;
    stop_d = stop_q;
    cmd    = '0;
    if (!stop_q) begin
      case (pos_q)
        GrpFirst: begin
          if (!sx.ok) begin
            stop_d = 1'b1;
          end else begin
            s0_d  = sx.val;
            pos_d = GrpSecond;
          end
        end
        GrpSecond: begin
          if (!sx.ok) begin
            stop_d = 1'b1;
          end else begin
            s1_d         = sx.val;
            cmd.has_byte = 1'b1;
            cmd.data     = {s0_q, sx.val[5:4]};
            pos_d        = GrpThird;
          end
        end
        GrpThird: begin
          if (is_pad) begin
            s2_d = '0;
          end else begin
            s2_d         = sx.val;
            cmd.has_byte = 1'b1;
            cmd.data     = {s1_q[3:0], sx.val[5:2]};
          end
          pos_d = GrpFourth;
        end
        default: begin
          if (!is_pad) begin
            cmd.has_byte = 1'b1;
            cmd.data     = {s2_q[1:0], sx.val};
          end
          pos_d = GrpFirst;
        end
      endcase
    end
    if (in_i.final_char) begin
      cmd.has_end = 1'b1;
      pos_d       = GrpFirst;
      s0_d        = '0;
      s1_d        = '0;
      s2_d        = '0;
      stop_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= GrpFirst;
      s0_q   <= '0;
      s1_q   <= '0;
      s2_q   <= '0;
      stop_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      s0_q   <= s0_d;
      s1_q   <= s1_d;
      s2_q   <= s2_d;
      stop_q <= stop_d;
    end
  end

  assign push_valid_o = accept & (cmd.has_byte | cmd.has_end);
  assign push_cmd_o   = cmd;

endmodule

// File: rtl/b64d_queue.sv
// Short command queue between front and back ends.
// Depends on b64d_pkg.
module b64d_queue #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  b64d_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output b64d_pkg::cmd_t pop_cmd_o
);
  import b64d_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ((wr_q == LastPtr) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == LastPtr) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// File: rtl/b64d_back.sv
// Back end: expands queued commands into result items through an output
// register. Depends on b64d_pkg and b64d_out_if.
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  b64d_pkg::cmd_t pop_cmd_i,
  b64d_out_if.source     out_o
);
  import b64d_pkg::*;

  logic       vld_q, vld_d;
  logic       phase_q, phase_d;
  logic [7:0] byte_q, byte_d;
  logic       bval_q, bval_d, last_q, last_d, end_q, end_d;
  logic       load;

  assign load = ~vld_q | out_o.ready;

  always_comb begin
    vld_d       = vld_q;
    phase_d     = phase_q;
    byte_d      = byte_q;
    bval_d      = bval_q;
    last_d      = last_q;
    end_d       = end_q;
    pop_ready_o = 1'b0;
    if (load) begin
      vld_d = pop_valid_i;
      if (pop_valid_i) begin
        if (pop_cmd_i.has_byte && !phase_q) begin
          byte_d      = pop_cmd_i.data;
          bval_d      = 1'b1;
          last_d      = ~pop_cmd_i.has_end;
          end_d       = 1'b0;
          phase_d     = pop_cmd_i.has_end;
          pop_ready_o = ~pop_cmd_i.has_end;
        end else begin
          byte_d      = '0;
          bval_d      = 1'b0;
          last_d      = 1'b1;
          end_d       = 1'b1;
          phase_d     = 1'b0;
          pop_ready_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    bval_q <= bval_d;
    last_q <= last_d;
    end_q  <= end_d;
  end

  assign out_o.valid      = vld_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.byte_valid = bval_q;
  assign out_o.run_last   = last_q;
  assign out_o.stream_end = end_q;

`ifndef SYNTHESIS
  a_phase_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (pop_valid_i && pop_cmd_i.has_byte && pop_cmd_i.has_end))
    else $error("split phase without a two-result head");
  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && end_q) |-> (last_q && !bval_q))
    else $error("end marker malformed");
  a_phase_next_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q && load) |=> (vld_q && end_q && !phase_q))
    else $error("end marker not sent after split byte");
`endif

endmodule

// File: test/tb.sv
// Testbench for base64_stream_decoder_core: directed and random character
// strings, checked against a behavioral decoder or a results table, under random
// idling on both channels. Depends on b64d_pkg, b64d_if and the decoder RTL.
module tb;
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_byte;
    logic       last_of_item;
    logic       is_end;
  } dec_result_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        fin;
    logic        typed;
    logic [1:0]  n;
    dec_result_t r0;
    dec_result_t r1;
  } dir_row_t;

  localparam int          WatchdogLimit = 2000;
  localparam int          StallHold     = 80;
  localparam int          ItemsPerPhase = 70;
  localparam int          DirCount      = 28;
  localparam dec_result_t NoRes         = '0;
  localparam dec_result_t EndMark       = '{8'h00, 1'b0, 1'b1, 1'b1};

  localparam dir_row_t DirRows [DirCount] = '{
    '{"T", 1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{"W", 1'b0, 1'b1, 2'd1, '{8'h4D, 1'b1, 1'b1, 1'b0}, NoRes},
    '{"F", 1'b0, 1'b1, 2'd1, '{8'h61, 1'b1, 1'b1, 1'b0}, NoRes},
    '{"u", 1'b1, 1'b1, 2'd2, '{8'h6E, 1'b1, 1'b0, 1'b0}, EndMark},
    '{"A", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"Z", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"a", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"z", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"0", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"9", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"+", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"/", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"A", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"/", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{PadChar, 1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{PadChar, 1'b1, 1'b1, 2'd1, EndMark, NoRes},
    '{"/", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"/", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{8'hFF, 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{8'h80, 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"Q", 1'b1, 1'b1, 2'd1, EndMark, NoRes},
    '{"Q", 1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{"*", 1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'h00, 1'b0, 1'b1, 2'd0, NoRes, NoRes},
    '{8'hFF, 1'b1, 1'b1, 2'd1, EndMark, NoRes},
    '{8'h00, 1'b1, 1'b1, 2'd1, EndMark, NoRes},
    '{"Q", 1'b0, 1'b0, 2'd0, NoRes, NoRes},
    '{"Q", 1'b1, 1'b0, 2'd0, NoRes, NoRes}
  };

  logic clk;
  logic rst_n;

  b64d_in_if  in_ch ();
  b64d_out_if out_ch ();

  base64_stream_decoder_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // decoder state
  logic [1:0] grp_pos;
  logic [5:0] sx_a;
  logic [5:0] sx_b;
  logic [5:0] sx_c;
  logic       stopped;

  dec_result_t step_q[$];
  dec_result_t pending_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int chars_sent     = 0;
  int live_chars     = 0;
  int strings_sent   = 0;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic [6:0] sextet_lookup(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return {1'b1, 6'(ch - "A")};
    if (ch >= "a" && ch <= "z") return {1'b1, 6'(ch - "a" + 8'd26)};
    if (ch >= "0" && ch <= "9") return {1'b1, 6'(ch - "0" + 8'd52)};
    if (ch == "+") return {1'b1, 6'd62};
    if (ch == "/") return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 6'd26);
    if (v < 6'd62) return 8'("0" + v - 6'd52);
    return (v == 6'd62) ? 8'("+") : 8'("/");
  endfunction

  task automatic add_byte(input logic [7:0] b);
    dec_result_t r;
    r      = '{b, 1'b1, 1'b0, 1'b0};
    step_q = {step_q, r};
  endtask

  task automatic clear_decoder();
    grp_pos = GrpFirst;
    sx_a    = '0;
    sx_b    = '0;
    sx_c    = '0;
    stopped = 1'b0;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic fin);
    logic [6:0] lk;
    logic       ok;
    logic [5:0] sx;
    lk = sextet_lookup(ch);
    ok = lk[6];
    sx = lk[5:0];
    step_q.delete();
    if (!stopped) begin
      live_chars++;
      case (grp_pos)
        GrpFirst: begin
          if (!ok) stopped = 1'b1;
          else begin
            sx_a    = sx;
            grp_pos = GrpSecond;
          end
        end
        GrpSecond: begin
          if (!ok) stopped = 1'b1;
          else begin
            sx_b = sx;
            add_byte({sx_a, sx_b[5:4]});
            grp_pos = GrpThird;
          end
        end
        GrpThird: begin
          if (ch == PadChar) sx_c = '0;
          else begin
            sx_c = sx;
            add_byte({sx_b[3:0], sx_c[5:2]});
          end
          grp_pos = GrpFourth;
        end
        default: begin
          if (ch != PadChar) add_byte({sx_c[1:0], sx});
          grp_pos = GrpFirst;
        end
      endcase
    end
    if (fin) begin
      step_q = {step_q, EndMark};
      clear_decoder();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last_of_item = 1'b1;
  endtask

  task automatic offer_char(input logic [7:0] ch, input logic fin, input bit keep_pred);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_char    <= ch;
    in_ch.final_char <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_char(ch, fin);
    if (keep_pred) pending_q = {pending_q, step_q};
    chars_sent++;
    if (fin) strings_sent++;
  endtask

  task automatic send_random_string();
    logic [7:0] text[$];
    int         tail;
    if ($urandom_range(99) < 75) begin
      repeat ($urandom_range(1, 3) * 4)
        text = {text, b64_char(6'($urandom_range(63)))};
      tail = $urandom_range(7);
      case (tail)
        1: text[text.size()-1] = PadChar;
        2: begin
          text[text.size()-1] = PadChar;
          text[text.size()-2] = PadChar;
        end
        3: text[text.size()-2] = PadChar;
        4: repeat ($urandom_range(1, 3)) text.delete(text.size() - 1);
        5: text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(1)) text = {text, 8'($urandom_range(255))};
        else text = {text, b64_char(6'($urandom_range(63)))};
      end
    end
    foreach (text[i]) offer_char(text[i], i == text.size() - 1, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_served != hold_asked) begin
      hold_served   <= hold_asked;
      hold_left     <= StallHold;
      out_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    dec_result_t got;
    dec_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.byte_valid, out_ch.run_last, out_ch.stream_end};
      results_seen++;
      if (pending_q.size() == 0) begin
        if (mismatches < 10)
          $display("mismatch: unexpected result data=%h byte=%b last=%b end=%b",
                   got.data, got.is_byte, got.last_of_item, got.is_end);
        mismatches++;
      end else begin
        want = pending_q.pop_front();
        if (got.data !== want.data || got.is_byte !== want.is_byte ||
            got.last_of_item !== want.last_of_item || got.is_end !== want.is_end) begin
          if (mismatches < 10)
            $display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b (data/byte/last/end)",
                     want.data, want.is_byte, want.last_of_item, want.is_end,
                     got.data, got.is_byte, got.last_of_item, got.is_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int target;
    in_ch.valid      = 1'b0;
    in_ch.in_char    = '0;
    in_ch.final_char = 1'b0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    clear_decoder();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DirCount; i++) begin
      offer_char(DirRows[i].ch, DirRows[i].fin, !DirRows[i].typed);
      if (DirRows[i].typed) begin
        if (DirRows[i].n > 0) pending_q = {pending_q, DirRows[i].r0};
        if (DirRows[i].n > 1) pending_q = {pending_q, DirRows[i].r1};
      end
    end
    drain();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_asked++;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      target = chars_sent + ItemsPerPhase;
      while (chars_sent < target) send_random_string();
      drain();
    end

    repeat (8) @(posedge clk);
    $display("summary: %0d strings, %0d characters (%0d decoded), %0d results checked",
             strings_sent, chars_sent, live_chars, results_seen);
    $display("summary: four idling phases, one long output hold-off, %0d mismatches",
             mismatches);
    if (mismatches == 0 && pending_q.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
